### hdl/rmq_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Holds the number format, the request and result structs and the pipeline widths.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps

package rmq_pkg;

  // Number format of matrix elements and quaternion components
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 30;

  // Width of a wide signed sum of three elements plus the unit term
  localparam int SUM_W  = DATA_WIDTH + 3;
  // Clamped radicand, magnitude of a sum or difference of two elements
  localparam int RAD_W  = DATA_WIDTH + 1;
  localparam int MAG_W  = DATA_WIDTH + 1;
  // Root of radicand * 2^FRAC_BITS, and the operand fed to the root unit
  localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int X_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  // Divider: denominator 2R, numerator |n| * 2^FRAC_BITS + R, quotient bits
  localparam int DEN_W  = ROOT_W + 1;
  localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
  localparam int Q_W    = DATA_WIDTH + 1;
  localparam int CMP_W  = DEN_W + Q_W;
  // Divider pipeline: operand stage, one stage per quotient bit, output stage
  localparam int DIV_LAT = Q_W + 2;

  typedef enum logic [1:0] {
    METH_TRACE = 2'd0,
    METH_X     = 2'd1,
    METH_Y     = 2'd2,
    METH_Z     = 2'd3
  } method_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] q_scalar;
    logic signed [DATA_WIDTH-1:0] q_x;
    logic signed [DATA_WIDTH-1:0] q_y;
    logic signed [DATA_WIDTH-1:0] q_z;
    logic [1:0]                   method_used;
    logic                         degenerate;
  } res_t;

  // One quotient lane: magnitude of the numerator and the sign of the result
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } lane_t;

  // Sideband that rides along the root pipeline
  typedef struct packed {
    method_e         meth;
    logic            half_neg;
    lane_t [2:0]     lane;
  } side_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    method_e           meth;
    logic              half_neg;
    logic [ROOT_W-1:0] root;
  } meta_t;

endpackage

### hdl/rmq_select.sv
// Front stage: trace, dominant term selection, radicand and quotient numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_select (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rmq_pkg::req_t        req_i,
  output logic                 valid_o,
  output logic [rmq_pkg::RAD_W-1:0] rad_o,
  output rmq_pkg::side_t       side_o
);

  localparam int TW = rmq_pkg::SUM_W;
  localparam logic signed [TW-1:0] OneT = TW'(1) <<< rmq_pkg::FRAC_BITS;

  function automatic logic signed [TW-1:0] sx(input logic signed [rmq_pkg::DATA_WIDTH-1:0] v);
    return TW'(v);
  endfunction

  function automatic rmq_pkg::lane_t mk_lane(input logic signed [TW-1:0] v, input logic flip);
    logic signed [TW-1:0] va;
    rmq_pkg::lane_t l;
    va = v[TW-1] ? -v : v;
    l.mag = va[rmq_pkg::MAG_W-1:0];
    l.neg = v[TW-1] ^ flip;
    return l;
  endfunction

  logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [TW-1:0] tr, best, term, rad_s, d, l1, l2;
  logic                 s_neg;
  rmq_pkg::method_e     meth;
  logic [rmq_pkg::RAD_W-1:0] rad_d;
  rmq_pkg::side_t       side_d;
  logic                 valid_q;
  logic [rmq_pkg::RAD_W-1:0] rad_q;
  rmq_pkg::side_t       side_q;

  // Pick the dominant term; the trace wins ties
  always_comb begin
    e00 = sx(req_i.m00); e01 = sx(req_i.m01); e02 = sx(req_i.m02);
    e10 = sx(req_i.m10); e11 = sx(req_i.m11); e12 = sx(req_i.m12);
    e20 = sx(req_i.m20); e21 = sx(req_i.m21); e22 = sx(req_i.m22);
    tr = e00 + e11 + e22;
    best = tr;
    meth = rmq_pkg::METH_TRACE;
    if (e00 > best) begin
      best = e00;
      meth = rmq_pkg::METH_X;
    end
    if (e11 > best) begin
      best = e11;
      meth = rmq_pkg::METH_Y;
    end
    if (e22 > best) begin
      best = e22;
      meth = rmq_pkg::METH_Z;
    end

    unique case (meth)
      rmq_pkg::METH_TRACE: begin
        term = tr;
        d  = e21 - e12;
        l1 = e02 - e20;
        l2 = e10 - e01;
      end
      rmq_pkg::METH_X: begin
        term = e00 - (e11 + e22);
        d  = e21 - e12;
        l1 = e01 + e10;
        l2 = e02 + e20;
      end
      rmq_pkg::METH_Y: begin
        term = e11 - (e22 + e00);
        d  = e02 - e20;
        l1 = e12 + e21;
        l2 = e10 + e01;
      end
      default: begin
        term = e22 - (e00 + e11);
        d  = e10 - e01;
        l1 = e20 + e02;
        l2 = e21 + e12;
      end
    endcase

    // Sign flip only for a dominant diagonal with a negative difference
    s_neg = (meth != rmq_pkg::METH_TRACE) && d[TW-1];

    // Clamp a negative radicand to zero
    rad_s = OneT + term;
    rad_d = rad_s[TW-1] ? '0 : rad_s[rmq_pkg::RAD_W-1:0];

    side_d.meth     = meth;
    side_d.half_neg = s_neg;
    side_d.lane[0]  = mk_lane(d, s_neg);
    side_d.lane[1]  = mk_lane(l1, s_neg);
    side_d.lane[2]  = mk_lane(l2, s_neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

### hdl/rmq_sqrt.sv
// Pipelined integer square root of radicand * 2^FRAC_BITS, one root bit per stage.
// Carries the selection sideband alongside. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [rmq_pkg::RAD_W-1:0]  rad_i,
  input  rmq_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [rmq_pkg::ROOT_W-1:0] root_o,
  output rmq_pkg::side_t             side_o
);

  localparam int NS    = rmq_pkg::ROOT_W;
  localparam int X_W   = rmq_pkg::X_W;
  localparam int REM_W = rmq_pkg::REM_W;

  logic                valid_q [NS];
  logic [X_W-1:0]      x_q     [NS];
  logic [REM_W-1:0]    rem_q   [NS];
  logic [NS-1:0]       root_q  [NS];
  rmq_pkg::side_t      side_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic             v_in;
    logic [X_W-1:0]   x_in;
    logic [REM_W-1:0] rem_in;
    logic [NS-1:0]    root_in;
    rmq_pkg::side_t   side_in;
    logic [REM_W-1:0] rem_sh, trial, rem_d;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = X_W'({rad_i, {rmq_pkg::FRAC_BITS{1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Bring in two operand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], x_in[X_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
      rem_d  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s]    <= {x_in[X_W-3:0], 2'b00};
      rem_q[s]  <= rem_d;
      root_q[s] <= {root_in[NS-2:0], ge};
      side_q[s] <= side_in;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

### hdl/rmq_div.sv
// Pipelined restoring divider for one lane: (|n| * 2^FRAC_BITS + R) / (2R),
// one quotient bit per stage, then sign and saturation. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [rmq_pkg::ROOT_W-1:0]          root_i,
  input  rmq_pkg::lane_t                      lane_i,
  output logic                                valid_o,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] val_o
);

  localparam int DW    = rmq_pkg::DATA_WIDTH;
  localparam int QW    = rmq_pkg::Q_W;
  localparam int NUM_W = rmq_pkg::NUM_W;
  localparam int DEN_W = rmq_pkg::DEN_W;
  localparam int CMP_W = rmq_pkg::CMP_W;
  localparam logic [QW-1:0] LimNeg = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] LimPos = LimNeg - QW'(1);

  logic               valid_q [QW+1];
  logic [NUM_W-1:0]   r_q     [QW+1];
  logic [DEN_W-1:0]   den_q   [QW+1];
  logic [QW-1:0]      q_q     [QW+1];
  logic               ovf_q   [QW+1];
  logic               neg_q   [QW+1];

  logic [NUM_W-1:0]   num_d;
  logic [DEN_W-1:0]   den_d;
  logic               ovf_d;

  // Form numerator and denominator; flag quotients beyond the kept bits
  always_comb begin
    num_d = NUM_W'({lane_i.mag, {rmq_pkg::FRAC_BITS{1'b0}}}) + NUM_W'(root_i);
    den_d = {root_i, 1'b0};
    ovf_d = (CMP_W'(num_d) >= (CMP_W'(den_d) << QW));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_d;
    den_q[0] <= den_d;
    q_q[0]   <= '0;
    ovf_q[0] <= ovf_d;
    neg_q[0] <= lane_i.neg;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [CMP_W-1:0] sub;
    logic             ge;

    // Try quotient bit QW - s
    always_comb begin
      sub = CMP_W'(den_q[s-1]) << (QW - s);
      ge  = (CMP_W'(r_q[s-1]) >= sub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[s]   <= ge ? r_q[s-1] - sub[NUM_W-1:0] : r_q[s-1];
      den_q[s] <= den_q[s-1];
      q_q[s]   <= {q_q[s-1][QW-2:0], ge};
      ovf_q[s] <= ovf_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  logic [QW-1:0] lim, qc, qs;
  logic          out_valid_q;
  logic signed [DW-1:0] val_q;

  // Saturate the magnitude, then apply the sign
  always_comb begin
    lim = neg_q[QW] ? LimNeg : LimPos;
    qc  = (ovf_q[QW] || (q_q[QW] > lim)) ? lim : q_q[QW];
    qs  = neg_q[QW] ? -qc : qc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= qs[DW-1:0];
  end

  assign valid_o = out_valid_q;
  assign val_o   = val_q;

endmodule

### hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, top level (Shepperd's method).
// Depends on rmq_pkg, rmq_select, rmq_sqrt and rmq_div.
//
// Usage:
//   A request is a 3x3 matrix on req_i, taken at a rising edge with start_i
//   high and busy_o low. busy_o stays low: the pipeline has no stall point,
//   so one matrix can be taken every cycle.
//   Each result appears on res_o for exactly one cycle with done_o high,
//   in request order. The receiver cannot hold results off, and needs not.
//   The pipeline is one selection stage, one root stage per root bit, one
//   divider stage per quotient bit plus operand and output stages, and the
//   output register. Throughput is one request per cycle.
//   The three quotients run in parallel dividers fed by the shared root.
//   Reset clears every valid bit at once; no result is pending afterwards.
//   A zero root gives zero components with the degenerate flag set.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rmq_pkg::req_t  req_i,
  output logic           done_o,
  output rmq_pkg::res_t  res_o
);

  localparam int DW  = rmq_pkg::DATA_WIDTH;
  localparam int RW  = rmq_pkg::ROOT_W;
  localparam int LAT = rmq_pkg::DIV_LAT;

  logic                       sel_valid;
  logic [rmq_pkg::RAD_W-1:0]  sel_rad;
  rmq_pkg::side_t             sel_side;
  logic                       sq_valid;
  logic [RW-1:0]              sq_root;
  rmq_pkg::side_t             sq_side;
  logic                       dv_valid [3];
  logic signed [DW-1:0]       dv_val   [3];
  rmq_pkg::meta_t             meta_in;
  rmq_pkg::meta_t             meta_q   [LAT];

  assign busy_o = 1'b0;

  rmq_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .req_i   (req_i),
    .valid_o (sel_valid),
    .rad_o   (sel_rad),
    .side_o  (sel_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .rad_i   (sel_rad),
    .side_i  (sel_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid),
      .root_i  (sq_root),
      .lane_i  (sq_side.lane[l]),
      .valid_o (dv_valid[l]),
      .val_o   (dv_val[l])
    );
  end

  // Delay the selection and root alongside the dividers
  always_comb begin
    meta_in.meth     = sq_side.meth;
    meta_in.half_neg = sq_side.half_neg;
    meta_in.root     = sq_root;
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_in;
    for (int s = 1; s < LAT; s++) begin
      meta_q[s] <= meta_q[s-1];
    end
  end

  logic [RW:0]          half_u;
  logic [DW:0]          half_s;
  logic signed [DW-1:0] hv;
  logic                 degen;
  rmq_pkg::res_t        res_d;
  logic                 done_q;
  rmq_pkg::res_t        res_q;

  // Place the half root and the quotients by the dominant term
  always_comb begin
    half_u = (RW + 1)'(meta_q[LAT-1].root) + (RW + 1)'(1);
    half_s = (DW + 1)'(half_u >> 1);
    half_s = meta_q[LAT-1].half_neg ? -half_s : half_s;
    hv     = half_s[DW-1:0];
    degen  = (meta_q[LAT-1].root == '0);

    res_d.method_used = meta_q[LAT-1].meth;
    res_d.degenerate  = degen;
    unique case (meta_q[LAT-1].meth)
      rmq_pkg::METH_TRACE: begin
        res_d.q_scalar = hv;
        res_d.q_x      = dv_val[0];
        res_d.q_y      = dv_val[1];
        res_d.q_z      = dv_val[2];
      end
      rmq_pkg::METH_X: begin
        res_d.q_scalar = dv_val[0];
        res_d.q_x      = hv;
        res_d.q_y      = dv_val[1];
        res_d.q_z      = dv_val[2];
      end
      rmq_pkg::METH_Y: begin
        res_d.q_scalar = dv_val[0];
        res_d.q_x      = dv_val[2];
        res_d.q_y      = hv;
        res_d.q_z      = dv_val[1];
      end
      default: begin
        res_d.q_scalar = dv_val[0];
        res_d.q_x      = dv_val[1];
        res_d.q_y      = dv_val[2];
        res_d.q_z      = hv;
      end
    endcase

    // Drop all components for a zero root
    if (degen) begin
      res_d.q_scalar = '0;
      res_d.q_x      = '0;
      res_d.q_y      = '0;
      res_d.q_z      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/rmq_checker.sv
// Port-level checker for the rotation matrix to quaternion converter.
// Depends on rmq_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module rmq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input rmq_pkg::res_t res_o
);

  // The pipeline never refuses a request
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("request refused");

  // A zero root zeroes every component
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.degenerate) |->
      (res_o.q_scalar == '0) && (res_o.q_x == '0) &&
      (res_o.q_y == '0) && (res_o.q_z == '0))
    else $error("degenerate result with nonzero component");

  // The scalar part is never negative
  a_scalar_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !res_o.q_scalar[rmq_pkg::DATA_WIDTH-1])
    else $error("negative scalar part");

  // Nothing comes out in the cycle right after reset is released
  a_no_early_done: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o)
    else $error("result without request");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

### tb/tb_rotation_matrix_to_quaternion.sv
// Testbench for the rotation matrix to quaternion converter.
// Drives directed and random matrices, predicts each quaternion and checks it.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

  localparam int     DW       = rmq_pkg::DATA_WIDTH;
  localparam int     FB       = rmq_pkg::FRAC_BITS;
  localparam longint ONE      = 64'sd1 << FB;
  localparam longint SMAX     = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint SMIN     = -SMAX - 1;
  localparam int     LATENCY  = 69;
  localparam int     N_RANDOM = 800;
  localparam int     N_DIR    = 20;
  localparam longint LIMIT    = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  rmq_pkg::req_t req_i = '0;
  logic done_o;
  rmq_pkg::res_t res_o;

  rmq_pkg::res_t quat_q[$];
  int     err_cnt = 0;
  longint cyc = 0;

  rotation_matrix_to_quaternion u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_w(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // n / (2R), rounded to nearest with ties away from zero
  function automatic longint half_recip(longint n, longint unsigned root);
    longint unsigned mag = (n < 0) ? longint'(-n) : longint'(n);
    longint unsigned q = ((mag << FB) + root) / (root << 1);
    if (q > longint'(SMAX) + 1) q = longint'(SMAX) + 1;
    return clamp_w(n < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic rmq_pkg::res_t shepperd(rmq_pkg::req_t r);
    longint m[3][3];
    longint q[4];
    longint tr, best, rad, d, s, half;
    longint unsigned root;
    int meth, i, j, k;
    rmq_pkg::res_t o;
    m[0][0] = r.m00; m[0][1] = r.m01; m[0][2] = r.m02;
    m[1][0] = r.m10; m[1][1] = r.m11; m[1][2] = r.m12;
    m[2][0] = r.m20; m[2][1] = r.m21; m[2][2] = r.m22;
    q = '{0, 0, 0, 0};
    meth = -1;
    tr = m[0][0] + m[1][1] + m[2][2];
    best = tr;
    // Trace wins ties; a diagonal must be strictly larger
    for (i = 0; i < 3; i++) begin
      if (m[i][i] > best) begin
        best = m[i][i];
        meth = i;
      end
    end
    i = (meth < 0) ? 0 : meth;
    j = (i + 1) % 3;
    k = (j + 1) % 3;
    if (meth < 0) rad = ONE + tr;
    else rad = ONE + m[i][i] - (m[j][j] + m[k][k]);
    if (rad < 0) rad = 0;
    root = int_sqrt(longint'(rad) << FB);
    if (root != 0) begin
      half = longint'((root + 1) >> 1);
      if (meth < 0) begin
        q[0] = clamp_w(half);
        q[1] = half_recip(m[2][1] - m[1][2], root);
        q[2] = half_recip(m[0][2] - m[2][0], root);
        q[3] = half_recip(m[1][0] - m[0][1], root);
      end else begin
        d = m[k][j] - m[j][k];
        s = (d < 0) ? -1 : 1;
        q[1 + i] = clamp_w(s * half);
        q[1 + j] = half_recip(s * (m[i][j] + m[j][i]), root);
        q[1 + k] = half_recip(s * (m[i][k] + m[k][i]), root);
        q[0] = half_recip(s * d, root);
      end
    end
    o.q_scalar = q[0];
    o.q_x = q[1];
    o.q_y = q[2];
    o.q_z = q[3];
    o.method_used = 2'(meth + 1);
    o.degenerate = (root == 0);
    return o;
  endfunction

  function automatic rmq_pkg::req_t diag_req(longint a, longint b, longint c);
    rmq_pkg::req_t r = '0;
    r.m00 = a;
    r.m11 = b;
    r.m22 = c;
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return SMAX;
      2: return SMIN;
      3: return {{(DW-1){1'b0}}, 1'b0};
      default: return $urandom_range(0, 2 * ONE) - ONE;
    endcase
  endfunction

  // Mostly small diagonals, often one near one, and three small off-diagonals
  function automatic rmq_pkg::req_t rand_req();
    rmq_pkg::req_t r;
    int pick;
    r = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 3);
      r.m00 = $urandom_range(0, ONE) - ONE / 2;
      r.m11 = $urandom_range(0, ONE) - ONE / 2;
      r.m22 = $urandom_range(0, ONE) - ONE / 2;
      if (pick == 1) r.m00 = ONE - $urandom_range(0, ONE / 4);
      if (pick == 2) r.m11 = ONE - $urandom_range(0, ONE / 4);
      if (pick == 3) r.m22 = ONE - $urandom_range(0, ONE / 4);
      r.m01 = $urandom_range(0, ONE) - ONE / 2;
      r.m10 = $urandom_range(0, ONE) - ONE / 2;
      r.m02 = $urandom_range(0, ONE) - ONE / 2;
    end
    return r;
  endfunction

  // Send one request, idling now and then outside the quiet stretch
  task automatic send(rmq_pkg::req_t r, bit quiet);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b1;
    req_i <= r;
    quat_q.push_back(shepperd(r));
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    rmq_pkg::res_t e;
    cyc <= cyc + 1;
    if (rst_ni && done_o) begin
      if (quat_q.size() == 0) begin
        $error("unexpected result %h", res_o);
        err_cnt++;
      end else begin
        e = quat_q.pop_front();
        if (res_o.q_scalar !== e.q_scalar) begin
          $error("q_scalar exp %h got %h", e.q_scalar, res_o.q_scalar); err_cnt++;
        end
        if (res_o.q_x !== e.q_x) begin
          $error("q_x exp %h got %h", e.q_x, res_o.q_x); err_cnt++;
        end
        if (res_o.q_y !== e.q_y) begin
          $error("q_y exp %h got %h", e.q_y, res_o.q_y); err_cnt++;
        end
        if (res_o.q_z !== e.q_z) begin
          $error("q_z exp %h got %h", e.q_z, res_o.q_z); err_cnt++;
        end
        if (res_o.method_used !== e.method_used) begin
          $error("method_used exp %0d got %0d", e.method_used, res_o.method_used);
          err_cnt++;
        end
        if (res_o.degenerate !== e.degenerate) begin
          $error("degenerate exp %0d got %0d", e.degenerate, res_o.degenerate);
          err_cnt++;
        end
      end
    end
    if (cyc > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  rmq_pkg::req_t dir_tab[N_DIR];
  rmq_pkg::res_t dir_exp[N_DIR];
  bit            dir_has[N_DIR];

  initial begin
    rmq_pkg::res_t p;
    rmq_pkg::res_t z;
    z = '0;
    for (int n = 0; n < N_DIR; n++) dir_has[n] = 1'b0;
    // Identity: trace dominates, scalar one, vector zero
    dir_tab[0] = diag_req(ONE, ONE, ONE);
    z.q_scalar = ONE; z.method_used = rmq_pkg::METH_TRACE;
    dir_exp[0] = z; dir_has[0] = 1'b1;
    // Half turns about each axis
    dir_tab[1] = diag_req(ONE, -ONE, -ONE);
    z = '0; z.q_x = ONE; z.method_used = rmq_pkg::METH_X;
    dir_exp[1] = z; dir_has[1] = 1'b1;
    dir_tab[2] = diag_req(-ONE, ONE, -ONE);
    z = '0; z.q_y = ONE; z.method_used = rmq_pkg::METH_Y;
    dir_exp[2] = z; dir_has[2] = 1'b1;
    dir_tab[3] = diag_req(-ONE, -ONE, ONE);
    z = '0; z.q_z = ONE; z.method_used = rmq_pkg::METH_Z;
    dir_exp[3] = z; dir_has[3] = 1'b1;
    // All-negative diagonals: the first diagonal wins, checked by the predictor
    dir_tab[4] = diag_req(-ONE, -ONE, -ONE);
    dir_tab[5] = diag_req(SMIN, SMIN, SMIN);
    // All zero: trace ties with diagonals and wins
    dir_tab[6] = '0;
    z = '0; z.q_scalar = ONE / 2; z.method_used = rmq_pkg::METH_TRACE;
    dir_exp[6] = z; dir_has[6] = 1'b1;
    // Extremes and tie cases, checked by the predictor
    dir_tab[7] = {9{SMAX[DW-1:0]}};
    dir_tab[8] = {9{SMIN[DW-1:0]}};
    dir_tab[9] = diag_req(SMAX, SMIN, SMIN);
    dir_tab[10] = diag_req(SMIN, SMAX, SMIN);
    dir_tab[11] = diag_req(SMIN, SMIN, SMAX);
    dir_tab[12] = diag_req(0, 0, -ONE);
    dir_tab[13] = diag_req(ONE / 2, ONE / 2, -ONE);
    dir_tab[14] = diag_req(-ONE / 2, -ONE / 2, -ONE / 2);
    dir_tab[15] = diag_req(0, -ONE, -ONE);
    dir_tab[15].m12 = SMAX; dir_tab[15].m21 = SMIN;
    dir_tab[16] = diag_req(-ONE, 0, -ONE);
    dir_tab[16].m20 = SMIN; dir_tab[16].m02 = SMAX;
    dir_tab[17] = diag_req(-ONE, -ONE, 0);
    dir_tab[17].m01 = SMAX; dir_tab[17].m10 = SMAX;
    dir_tab[18] = {9{32'hFFFF_FFFF}};
    dir_tab[19] = {9{32'h5555_5555}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Walk the directed table
    for (int n = 0; n < N_DIR; n++) begin
      send(dir_tab[n], 1'b0);
      p = quat_q[quat_q.size() - 1];
      if (dir_has[n] && p !== dir_exp[n]) begin
        $error("predictor row %0d exp %h got %h", n, dir_exp[n], p);
        err_cnt++;
      end
    end
    // Random part, with a quiet stretch in the middle
    for (int n = 0; n < N_RANDOM; n++) send(rand_req(), n >= 300 && n < 450);
    @(posedge clk_i);
    start_i <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
